### hw/rtl/sams_pkg.sv
// Shared types and constants for the servo axis mode sequencer.
package sams_pkg;

  // Field widths of the scan and result beats.
  localparam int unsigned StatusW = 10;
  localparam int unsigned ReqW    = 7;
  localparam int unsigned CmdW    = 10;
  localparam int unsigned DtW     = 8;
  localparam int unsigned TmoW    = 16;

  // Reset value of the drive-ready timeout in milliseconds.
  localparam logic [TmoW-1:0] DefaultReadyTimeout = 16'd20000;

  // Configuration register indexes.
  localparam logic [1:0] RegSimulated  = 2'd0;
  localparam logic [1:0] RegHomeDirect = 2'd1;
  localparam logic [1:0] RegTimeout    = 2'd2;

  // Drive status bits.
  localparam int unsigned StBasic   = 0;
  localparam int unsigned StCfgDone = 1;
  localparam int unsigned StInited  = 2;
  localparam int unsigned StReady   = 3;
  localparam int unsigned StPowered = 4;
  localparam int unsigned StHomed   = 5;
  localparam int unsigned StInPos   = 6;
  localparam int unsigned StBusy    = 7;
  localparam int unsigned StMoving  = 8;
  localparam int unsigned StInSync  = 9;

  // Drive command bits.
  localparam int unsigned CmdPower  = 0;
  localparam int unsigned CmdHome   = 1;
  localparam int unsigned CmdAbs    = 2;
  localparam int unsigned CmdAdd    = 3;
  localparam int unsigned CmdVel    = 4;
  localparam int unsigned CmdJogNeg = 5;
  localparam int unsigned CmdJogPos = 6;
  localparam int unsigned CmdCouple = 7;
  localparam int unsigned CmdSave   = 8;
  localparam int unsigned CmdUpdate = 9;

  // Request bits, also used for the request clear mask.
  localparam int unsigned ReqHome   = 0;
  localparam int unsigned ReqAbs    = 1;
  localparam int unsigned ReqAdd    = 2;
  localparam int unsigned ReqVel    = 3;
  localparam int unsigned ReqJogNeg = 4;
  localparam int unsigned ReqJogPos = 5;
  localparam int unsigned ReqCouple = 6;

  // Home parameter selection codes.
  localparam logic [1:0] HselNone   = 2'd0;
  localparam logic [1:0] HselDirect = 2'd1;
  localparam logic [1:0] HselConfig = 2'd2;

  // Axis sequence states.
  typedef enum logic [3:0] {
    ST_INIT    = 4'd0,
    ST_PREP    = 4'd1,
    ST_POWER   = 4'd2,
    ST_HOME    = 4'd3,
    ST_WHOME   = 4'd4,
    ST_IDLE    = 4'd5,
    ST_MOVE    = 4'd6,
    ST_VEL     = 4'd7,
    ST_WCOUPLE = 4'd8,
    ST_COUPLED = 4'd9,
    ST_ERROR   = 4'd10
  } axis_state_e;

  // Configuration register contents.
  typedef struct packed {
    logic            simulated;
    logic            home_direct;
    logic [TmoW-1:0] ready_timeout;
  } cfg_t;

  // Sequence state carried from scan to scan (timer count kept apart).
  typedef struct packed {
    axis_state_e     state;
    logic [CmdW-1:0] cmd;
    logic            home_done;
    logic            timed_out;
  } seq_t;

  // Per-scan results that are not part of the carried state.
  typedef struct packed {
    logic [ReqW-1:0] req_clear;
    logic            move_done;
    logic [1:0]      home_sel;
  } res_t;

endpackage

### hw/rtl/sams_cfg_regs.sv
// APB configuration registers of the servo axis mode sequencer.
module sams_cfg_regs
  import sams_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write decode; addresses past the last register are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        RegSimulated:  cfg_d.simulated     = pwdata[0];
        RegHomeDirect: cfg_d.home_direct   = pwdata[0];
        RegTimeout:    cfg_d.ready_timeout = pwdata[TmoW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.simulated     <= 1'b0;
      cfg_q.home_direct   <= 1'b0;
      cfg_q.ready_timeout <= DefaultReadyTimeout;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[3:2])
      RegSimulated:  prdata = {31'd0, cfg_q.simulated};
      RegHomeDirect: prdata = {31'd0, cfg_q.home_direct};
      RegTimeout:    prdata = {{(32 - TmoW){1'b0}}, cfg_q.ready_timeout};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/sams_step.sv
// One scan step of the axis sequence and the drive-ready timer.
module sams_step
  import sams_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  cfg_t                  cfg_i,
  input  seq_t                  seq_i,
  input  logic [TIMER_BITS-1:0] elapsed_i,
  input  logic                  alarm_i,
  input  logic [StatusW-1:0]    status_i,
  input  logic [ReqW-1:0]       req_i,
  input  logic [DtW-1:0]        dt_i,
  output seq_t                  seq_o,
  output logic [TIMER_BITS-1:0] elapsed_o,
  output res_t                  res_o
);

  localparam int unsigned CmpW = (TIMER_BITS >= TmoW) ? TIMER_BITS + 1 : TmoW + 1;

  axis_state_e     st;
  logic [CmdW-1:0] cmd;
  logic            hdone;
  logic [ReqW-1:0] clr;
  logic            done;
  logic [1:0]      hsel;
  logic            timer_in;
  logic [CmpW-1:0] sum;
  logic [CmpW-1:0] limit;
  logic [CmpW-1:0] tmax;
  logic [CmpW-1:0] capped;

  // Sequence step: alarm overrides, jog commands drop every scan.
  always_comb begin
    st       = alarm_i ? ST_ERROR : seq_i.state;
    cmd      = seq_i.cmd;
    hdone    = seq_i.home_done;
    clr      = '0;
    done     = 1'b0;
    hsel     = HselNone;
    timer_in = 1'b0;
    cmd[CmdJogNeg] = 1'b0;
    cmd[CmdJogPos] = 1'b0;

    unique case (st)
      ST_INIT: begin
        if (status_i[StBasic]) begin
          cmd[CmdSave] = 1'b1;
          if (status_i[StCfgDone]) begin
            cmd[CmdSave]   = 1'b0;
            cmd[CmdUpdate] = 1'b0;
          end
          st = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd[CmdUpdate] = 1'b1;
        if (status_i[StInited]) begin
          cmd[CmdPower] = 1'b0;
          st = ST_POWER;
        end
      end
      ST_POWER: begin
        if (status_i[StReady] || seq_i.timed_out) begin
          cmd[CmdPower] = 1'b1;
          if (status_i[StPowered]) st = ST_HOME;
        end else begin
          timer_in = 1'b1;
        end
      end
      ST_HOME: begin
        if (status_i[StReady]) begin
          if (!seq_i.home_done || !status_i[StHomed]) begin
            if (cfg_i.simulated || cfg_i.home_direct) begin
              hsel = HselDirect;
              clr[ReqHome] = 1'b1;
              cmd[CmdHome] = 1'b1;
              st = ST_WHOME;
            end else if (req_i[ReqHome]) begin
              hsel = HselConfig;
              clr[ReqHome] = 1'b1;
              cmd[CmdHome] = 1'b1;
              st = ST_WHOME;
            end
          end else begin
            st = ST_IDLE;
          end
        end
      end
      ST_WHOME: begin
        if (status_i[StHomed]) begin
          cmd[CmdHome] = 1'b0;
          hdone = 1'b1;
          st = ST_IDLE;
        end
      end
      ST_IDLE: begin
        priority if (req_i[ReqHome]) begin
          hdone = 1'b0;
          st = ST_HOME;
        end else if (req_i[ReqAbs]) begin
          clr[ReqAbs] = 1'b1;
          cmd[CmdAbs] = 1'b1;
          st = ST_MOVE;
        end else if (req_i[ReqAdd]) begin
          clr[ReqAdd] = 1'b1;
          cmd[CmdAdd] = 1'b1;
          st = ST_MOVE;
        end else if (req_i[ReqVel]) begin
          cmd[CmdVel] = 1'b1;
          st = ST_VEL;
        end else if (req_i[ReqJogNeg]) begin
          cmd[CmdJogNeg] = 1'b1;
        end else if (req_i[ReqJogPos]) begin
          cmd[CmdJogPos] = 1'b1;
        end else if (req_i[ReqCouple]) begin
          cmd[CmdCouple] = 1'b1;
          st = ST_WCOUPLE;
        end else begin
          st = ST_IDLE;
        end
      end
      ST_MOVE: begin
        if (status_i[StInPos] && !status_i[StBusy]) begin
          done = 1'b1;
          cmd[CmdAbs] = 1'b0;
          cmd[CmdAdd] = 1'b0;
          st = ST_IDLE;
        end
      end
      ST_VEL: begin
        if (!req_i[ReqVel]) begin
          cmd[CmdVel] = 1'b0;
          st = ST_IDLE;
        end
      end
      ST_WCOUPLE: begin
        if (status_i[StInSync]) st = ST_COUPLED;
      end
      ST_COUPLED: begin
        if (!req_i[ReqCouple]) begin
          cmd[CmdCouple] = 1'b0;
          if (!status_i[StInSync]) st = ST_IDLE;
        end
      end
      ST_ERROR: begin
        clr = '1;
        cmd[CmdHome]   = 1'b0;
        cmd[CmdAbs]    = 1'b0;
        cmd[CmdAdd]    = 1'b0;
        cmd[CmdVel]    = 1'b0;
        cmd[CmdCouple] = 1'b0;
        cmd[CmdSave]   = 1'b1;
        if (!status_i[StMoving]) cmd[CmdPower] = 1'b0;
        if (!alarm_i) st = ST_INIT;
      end
      default: begin
        st = seq_i.state;
      end
    endcase
  end

  // Ready timer: saturating add, capped at the timeout and the counter range.
  assign sum    = CmpW'(elapsed_i) + CmpW'(dt_i);
  assign limit  = CmpW'(cfg_i.ready_timeout);
  assign tmax   = CmpW'({TIMER_BITS{1'b1}});

  always_comb begin
    capped = (sum > limit) ? limit : sum;
    if (capped > tmax) capped = tmax;
  end

  assign elapsed_o       = timer_in ? capped[TIMER_BITS-1:0] : '0;
  assign seq_o.state     = st;
  assign seq_o.cmd       = cmd;
  assign seq_o.home_done = hdone;
  assign seq_o.timed_out = timer_in && (capped >= limit);
  assign res_o.req_clear = clr;
  assign res_o.move_done = done;
  assign res_o.home_sel  = hsel;

endmodule

### hw/rtl/servo_axis_mode_sequencer.sv
// Top level of the servo axis mode sequencer: scan register, state and result register.
//
// Usage: each input beat is one control scan (alarm, drive status, operator
// requests, scan time). Each scan gives exactly one result beat with the axis
// state, drive command bits, request clear mask, move-complete pulse, home
// parameter selection, home-done flag and ready-timeout flag.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// On the way from an accepted scan to its result beat, the scan is
// registered, the combinational step logic updates the sequence state, and the
// result lands in the output register. Throughput is one scan per cycle while
// the receiver does not stall; the sequence state is updated in the same cycle
// that the scan moves to the output register, so the next scan sees it at once.
// When the receiver stalls, the result beat holds; one more scan waits in the
// scan register, after which in_stall_o rises until the result is taken.
// Reset puts the axis in init with all commands off, the home-done flag and
// ready timer cleared, and the registers at their defaults (timeout 20000 ms).
// Configuration is to be written over APB only while no scan is in flight (user's duty; not enforced).
module servo_axis_mode_sequencer
  import sams_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Scan channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               alarm_active_i,
  input  logic [StatusW-1:0] drive_status_i,
  input  logic [ReqW-1:0]    requests_i,
  input  logic [DtW-1:0]     scan_time_ms_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         axis_state_code_o,
  output logic [CmdW-1:0]    drive_commands_o,
  output logic [ReqW-1:0]    request_clear_o,
  output logic               move_complete_o,
  output logic [1:0]         home_param_select_o,
  output logic               first_home_done_o,
  output logic               ready_timed_out_o
);

  cfg_t                  cfg;
  logic                  scan_valid_q;
  logic                  alarm_q;
  logic [StatusW-1:0]    status_q;
  logic [ReqW-1:0]       req_q;
  logic [DtW-1:0]        dt_q;
  seq_t                  seq_q, seq_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  res_t                  res_d;
  logic                  out_valid_q;
  seq_t                  out_seq_q;
  res_t                  out_res_q;
  logic                  out_free;
  logic                  advance;
  logic                  in_take;

  sams_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sams_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cfg_i     (cfg),
    .seq_i     (seq_q),
    .elapsed_i (elapsed_q),
    .alarm_i   (alarm_q),
    .status_i  (status_q),
    .req_i     (req_q),
    .dt_i      (dt_q),
    .seq_o     (seq_d),
    .elapsed_o (elapsed_d),
    .res_o     (res_d)
  );

  // Handshake: the scan register drains whenever the result register can load.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = scan_valid_q && out_free;
  assign in_stall_o = scan_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_valid_q    <= 1'b0;
      out_valid_q     <= 1'b0;
      seq_q.state     <= ST_INIT;
      seq_q.cmd       <= '0;
      seq_q.home_done <= 1'b0;
      seq_q.timed_out <= 1'b0;
      elapsed_q       <= '0;
    end else begin
      if (in_take) begin
        scan_valid_q <= 1'b1;
      end else if (advance) begin
        scan_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= scan_valid_q;
      end
      if (advance) begin
        seq_q     <= seq_d;
        elapsed_q <= elapsed_d;
      end
    end
  end

  // Scan and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      alarm_q  <= alarm_active_i;
      status_q <= drive_status_i;
      req_q    <= requests_i;
      dt_q     <= scan_time_ms_i;
    end
    if (advance) begin
      out_seq_q <= seq_d;
      out_res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign axis_state_code_o   = out_seq_q.state;
  assign drive_commands_o    = out_seq_q.cmd;
  assign first_home_done_o   = out_seq_q.home_done;
  assign ready_timed_out_o   = out_seq_q.timed_out;
  assign request_clear_o     = out_res_q.req_clear;
  assign move_complete_o     = out_res_q.move_done;
  assign home_param_select_o = out_res_q.home_sel;

`ifndef SYNTHESIS
  // The ready timer only holds its flag while the axis waits in power-on.
  a_timeout_in_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q.timed_out |-> seq_q.state == ST_POWER)
    else $error("ready timeout flag set outside power-on");

  // A finished move always lands in idle.
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && move_complete_o |-> axis_state_code_o == ST_IDLE)
    else $error("move complete without return to idle");

  // A home parameter selection comes with the home command and wait-home state.
  a_home_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (home_param_select_o != HselNone) |->
      drive_commands_o[CmdHome] && axis_state_code_o == ST_WHOME)
    else $error("home selection without home command");

  // The sequence state only moves when a scan goes to the result register.
  a_state_moves_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(seq_q))
    else $error("sequence state changed without a scan");
`endif

endmodule
